// ===== design/gdas_pkg.sv =====
package gdas_pkg;

    localparam logic [13:0] MIN_YEAR = 14'd1583;
    localparam logic [13:0] MAX_YEAR = 14'd9999;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic        func;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [14:0] count;
    } in_t;

    typedef struct packed {
        logic [4:0]  res_day;
        logic [3:0]  res_month;
        logic [13:0] res_year;
        logic        valid_res;
    } out_t;

    // working date plus year bookkeeping: year % 100 and (year / 100) % 4
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  rem100;
        logic [1:0]  cent4;
    } cal_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INIT,
        ST_CHECK,
        ST_RUN,
        ST_DONE
    } state_t;

    function automatic logic is_leap(logic [1:0] y_lo, logic [6:0] rem100, logic [1:0] cent4);
        is_leap = (y_lo == 2'd0) && ((rem100 != 7'd0) || (cent4 == 2'd0));
    endfunction

    function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     month_days = 5'd30;
            4'd2:                                        month_days = leap ? 5'd29 : 5'd28;
            default:                                     month_days = 5'd0;
        endcase
    endfunction

endpackage

// ===== design/gdas_step.sv =====
module gdas_step (
    input  gdas_pkg::cal_t cur,
    input  logic           func,
    output gdas_pkg::cal_t nxt
);

    logic       cur_leap;
    logic [4:0] cur_len;
    logic [1:0] prev_y_lo;
    logic [6:0] prev_rem;
    logic [1:0] prev_cent;
    logic [4:0] prev_dec_len;
    logic [4:0] prev_wrap_len;

    always_comb
    begin
        cur_leap      = gdas_pkg::is_leap(cur.year[1:0], cur.rem100, cur.cent4);
        cur_len       = gdas_pkg::month_days(cur.month, cur_leap);

        // previous year for the January to December wrap when going back
        prev_y_lo     = cur.year[1:0] - 2'd1;
        prev_rem      = (cur.rem100 == 7'd0) ? 7'd99 : cur.rem100 - 7'd1;
        prev_cent     = (cur.rem100 == 7'd0) ? cur.cent4 - 2'd1 : cur.cent4;
        prev_dec_len  = gdas_pkg::month_days(cur.month - 4'd1, cur_leap);
        prev_wrap_len = gdas_pkg::month_days(4'd12,
                            gdas_pkg::is_leap(prev_y_lo, prev_rem, prev_cent));

        nxt = cur;
        if (func == gdas_pkg::OP_ADD)
        begin
            if (cur.day >= cur_len)
            begin
                nxt.day = 5'd1;
                if (cur.month == 4'd12)
                begin
                    nxt.month  = 4'd1;
                    nxt.year   = cur.year + 14'd1;
                    nxt.rem100 = (cur.rem100 == 7'd99) ? 7'd0 : cur.rem100 + 7'd1;
                    nxt.cent4  = (cur.rem100 == 7'd99) ? cur.cent4 + 2'd1 : cur.cent4;
                end
                else
                begin
                    nxt.month = cur.month + 4'd1;
                end
            end
            else
            begin
                nxt.day = cur.day + 5'd1;
            end
        end
        else
        begin
            if (cur.day > 5'd1)
            begin
                nxt.day = cur.day - 5'd1;
            end
            else if (cur.month > 4'd1)
            begin
                nxt.month = cur.month - 4'd1;
                nxt.day   = prev_dec_len;
            end
            else
            begin
                nxt.month  = 4'd12;
                nxt.year   = cur.year - 14'd1;
                nxt.rem100 = prev_rem;
                nxt.cent4  = prev_cent;
                nxt.day    = prev_wrap_len;
            end
        end
    end

endmodule

// ===== design/gregorian_date_add_sub_days_unit.sv =====
// Sequence from request accept to result valid for a valid date: divide, init,
// check, the day steps, then a step that sees the end; an invalid date goes
// from check to the result; stepping ends early when the calendar bound is reached.
// One request at a time: a new request is taken only once the result is accepted
// and the sequencer is back in idle; the day stepper advances one day per cycle.
// Reset: rst_n clears the sequencer to idle; no result is pending after reset.
module gregorian_date_add_sub_days_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gdas_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output gdas_pkg::out_t  out_data
);

    gdas_pkg::state_t state_reg, state_next;
    gdas_pkg::cal_t   date_reg, date_next;
    gdas_pkg::cal_t   step_date;
    logic [14:0]      count_reg, count_next;
    logic             func_reg, func_next;
    logic [7:0]       quot_reg, quot_next;
    logic             ok_reg, ok_next;

    logic [26:0]      div_prod;
    logic [14:0]      quot_x100;
    logic [14:0]      rem_wide;
    logic [4:0]       start_len;
    logic             start_ok;
    logic             at_bound;

    gdas_step u_step (
        .cur  (date_reg),
        .func (func_reg),
        .nxt  (step_date)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gdas_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        date_reg  <= date_next;
        count_reg <= count_next;
        func_reg  <= func_next;
        quot_reg  <= quot_next;
        ok_reg    <= ok_next;
    end

    always_comb
    begin
        div_prod  = 27'(date_reg.year) * 27'(gdas_pkg::DIV100_MUL);
        quot_x100 = {1'b0, quot_reg, 6'b0} + {2'b0, quot_reg, 5'b0} + {5'b0, quot_reg, 2'b0};
        rem_wide  = {1'b0, date_reg.year} - quot_x100;

        start_len = gdas_pkg::month_days(date_reg.month,
                        gdas_pkg::is_leap(date_reg.year[1:0], date_reg.rem100, date_reg.cent4));
        start_ok  = (date_reg.month >= 4'd1) && (date_reg.month <= 4'd12)
                 && (date_reg.day >= 5'd1) && (date_reg.day <= start_len)
                 && (date_reg.year >= gdas_pkg::MIN_YEAR)
                 && (date_reg.year <= gdas_pkg::MAX_YEAR);

        at_bound  = (func_reg == gdas_pkg::OP_SUB)
                  ? (date_reg.day == 5'd1 && date_reg.month == 4'd1
                     && date_reg.year == gdas_pkg::MIN_YEAR)
                  : (date_reg.day == 5'd31 && date_reg.month == 4'd12
                     && date_reg.year == gdas_pkg::MAX_YEAR);
    end

    always_comb
    begin
        state_next = state_reg;
        date_next  = date_reg;
        count_next = count_reg;
        func_next  = func_reg;
        quot_next  = quot_reg;
        ok_next    = ok_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            gdas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    date_next.day    = in_data.day;
                    date_next.month  = in_data.month;
                    date_next.year   = in_data.year;
                    date_next.rem100 = 7'd0;
                    date_next.cent4  = 2'd0;
                    count_next       = in_data.count;
                    func_next        = in_data.func;
                    state_next       = gdas_pkg::ST_DIV;
                end
            end
            gdas_pkg::ST_DIV:
            begin
                quot_next  = div_prod[26:gdas_pkg::DIV100_SHIFT];
                state_next = gdas_pkg::ST_INIT;
            end
            gdas_pkg::ST_INIT:
            begin
                date_next.rem100 = rem_wide[6:0];
                date_next.cent4  = quot_reg[1:0];
                state_next       = gdas_pkg::ST_CHECK;
            end
            gdas_pkg::ST_CHECK:
            begin
                ok_next    = start_ok;
                state_next = start_ok ? gdas_pkg::ST_RUN : gdas_pkg::ST_DONE;
            end
            gdas_pkg::ST_RUN:
            begin
                if (count_reg == 15'd0 || at_bound)
                begin
                    state_next = gdas_pkg::ST_DONE;
                end
                else
                begin
                    date_next  = step_date;
                    count_next = count_reg - 15'd1;
                end
            end
            gdas_pkg::ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = gdas_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gdas_pkg::ST_IDLE;
            end
        endcase

        out_data.res_day   = date_reg.day;
        out_data.res_month = date_reg.month;
        out_data.res_year  = date_reg.year;
        out_data.valid_res = ok_reg;
    end

endmodule
